### src/blfcm_pkg.sv
// Package for the bank latch / flash command mapper.
// Holds payload structs, control structs, state enums and fixed constants.
// No dependencies.
package blfcm_pkg;

   // Fixed field widths
   localparam int ADDR_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int BANK_W   = 5;
   localparam int OFFSET_W = 14;
   localparam int CNT_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   typedef logic [CNT_W-1:0] cnt_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_ENABLED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_VARIANT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NAMETABLE_MODE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_BANK_MASK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_BANK_COUNT = 3'd4;

   // Command protocol addresses and data
   localparam logic [ADDR_W-1:0] ADDR_LATCH = 16'hC000;
   localparam logic [ADDR_W-1:0] ADDR_UNLK1 = 16'h9555;
   localparam logic [ADDR_W-1:0] ADDR_UNLK2 = 16'hAAAA;
   localparam logic [BYTE_W-1:0] DATA_RESET   = 8'hF0;
   localparam logic [BYTE_W-1:0] DATA_ID      = 8'h90;
   localparam logic [BYTE_W-1:0] DATA_PROGRAM = 8'hA0;
   localparam logic [BYTE_W-1:0] DATA_ERASE   = 8'h80;
   localparam logic [BYTE_W-1:0] DATA_SECTOR  = 8'h30;
   localparam logic [BYTE_W-1:0] DATA_AA      = 8'hAA;
   localparam logic [BYTE_W-1:0] DATA_55      = 8'h55;
   localparam logic [BYTE_W-1:0] DATA_00      = 8'h00;
   localparam logic [BYTE_W-1:0] DATA_01      = 8'h01;
   localparam logic [OFFSET_W-1:0] SECTOR_MASK = 14'h3000;

   // Device ID bytes
   localparam logic [BYTE_W-1:0] DEV_ID_32 = 8'hB7;
   localparam logic [BYTE_W-1:0] DEV_ID_16 = 8'hB6;
   localparam logic [BYTE_W-1:0] DEV_ID_LO = 8'hB5;

   // Board variants with special decode
   localparam logic [2:0] VARIANT_0 = 3'd0;
   localparam logic [2:0] VARIANT_1 = 3'd1;
   localparam logic [2:0] VARIANT_2 = 3'd2;
   localparam logic [2:0] VARIANT_3 = 3'd3;
   localparam logic [2:0] VARIANT_4 = 3'd4;

   // Nametable modes
   localparam logic [1:0] NT_HORIZONTAL = 2'd0;
   localparam logic [1:0] NT_VERTICAL   = 2'd1;
   localparam logic [1:0] NT_ONE_SCREEN = 2'd2;
   localparam logic [1:0] NT_FOUR       = 2'd3;

   // Mirroring codes
   localparam logic [2:0] MIR_HORIZONTAL = 3'd0;
   localparam logic [2:0] MIR_VERTICAL   = 3'd1;
   localparam logic [2:0] MIR_SCREEN_A   = 3'd2;
   localparam logic [2:0] MIR_SCREEN_B   = 3'd3;
   localparam logic [2:0] MIR_FOUR       = 3'd4;

   // Flash operations
   localparam logic [1:0] FOP_NONE    = 2'd0;
   localparam logic [1:0] FOP_PROGRAM = 2'd1;
   localparam logic [1:0] FOP_ERASE   = 2'd2;

   // Flash command sequencer states
   typedef enum logic [3:0] {
      SEQ_IDLE      = 4'd0,
      SEQ_U1        = 4'd1,
      SEQ_U2        = 4'd2,
      SEQ_U3        = 4'd3,
      SEQ_U4        = 4'd4,
      SEQ_CMD       = 4'd5,
      SEQ_PGM_BANK  = 4'd6,
      SEQ_PGM_DATA  = 4'd7,
      SEQ_ERS_U1    = 4'd8,
      SEQ_ERS_U2    = 4'd9,
      SEQ_ERS_U3    = 4'd10,
      SEQ_ERS_BANK  = 4'd11,
      SEQ_ERS_DATA  = 4'd12
   } flash_seq_type;

   // Controller states
   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_CALC = 2'd1,
      CTL_DONE = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] write_data;
      logic [BYTE_W-1:0] rom_value;
   } req_type;

   typedef struct packed {
      logic [BANK_W-1:0]   prg_bank;
      logic [1:0]          chr_bank;
      logic [2:0]          mirroring;
      logic                id_view;
      logic [BYTE_W-1:0]   device_id;
      logic [1:0]          flash_op;
      logic [BANK_W-1:0]   flash_bank;
      logic [OFFSET_W-1:0] flash_offset;
      logic [BYTE_W-1:0]   flash_data;
      logic                latch_updated;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic store;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_step;
   } dp_status_type;

endpackage

### src/blfcm_ctrl.sv
// Controller for the bank latch / flash command mapper.
// Sequences accept, bank modulo iteration and result store; owns rsp valid.
// Depends on blfcm_pkg.
module blfcm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output blfcm_pkg::ctl_cmd_type   cmd,
   input  blfcm_pkg::dp_status_type status
);

   blfcm_pkg::ctl_state_type state_ff, state_in;
   logic out_full_ff, out_full_in;
   logic out_free;

   // result register can take a new result
   assign out_free  = !out_full_ff || !rsp_stall;
   assign req_stall = (state_ff != blfcm_pkg::CTL_IDLE);
   assign rsp_valid = out_full_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         blfcm_pkg::CTL_IDLE: begin
            if (req_valid) state_in = blfcm_pkg::CTL_CALC;
         end
         blfcm_pkg::CTL_CALC: begin
            if (status.last_step) state_in = blfcm_pkg::CTL_DONE;
         end
         blfcm_pkg::CTL_DONE: begin
            if (out_free) state_in = blfcm_pkg::CTL_IDLE;
         end
         default: state_in = blfcm_pkg::CTL_IDLE;
      endcase
   end

   // outputs to datapath
   always_comb begin
      cmd = '0;
      case (state_ff)
         blfcm_pkg::CTL_IDLE: cmd.load  = req_valid;
         blfcm_pkg::CTL_CALC: cmd.step  = 1'b1;
         blfcm_pkg::CTL_DONE: cmd.store = out_free;
         default: cmd = '0;
      endcase
   end

   // result register occupancy
   always_comb begin
      out_full_in = out_full_ff;
      if (cmd.store) out_full_in = 1'b1;
      else if (!rsp_stall) out_full_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= blfcm_pkg::CTL_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

endmodule

### src/blfcm_datapath.sv
// Datapath for the bank latch / flash command mapper.
// Config registers, bank latch, flash command sequencer, serial modulo, result register.
// Depends on blfcm_pkg.
module blfcm_datapath #(
   parameter int PRG_BANK_BITS = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [blfcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [blfcm_pkg::CSR_DATA_W-1:0]      csr_data,
   input  blfcm_pkg::req_type                    req_payload,
   output blfcm_pkg::rsp_type                    rsp_payload,
   input  blfcm_pkg::ctl_cmd_type                cmd,
   output blfcm_pkg::dp_status_type              status
);

   localparam int P  = PRG_BANK_BITS;
   localparam int RW = P + 1;
   localparam int SW = $clog2(P);
   localparam blfcm_pkg::cnt_type MAX_COUNT = blfcm_pkg::cnt_type'(1 << P);

   // configuration
   logic                         flash_en_ff;
   logic [2:0]                   variant_ff;
   logic [1:0]                   nt_mode_ff;
   logic [1:0]                   chr_mask_ff;
   blfcm_pkg::cnt_type           bank_count_ff;

   // mapper state
   logic [blfcm_pkg::BYTE_W-1:0] latch_ff, latch_in;
   blfcm_pkg::flash_seq_type     seq_ff, seq_in;
   logic [P-1:0]                 tbank_ff, tbank_in;
   logic                         idv_ff, idv_in;

   // per-item flash command, held until store
   logic [1:0]                     op_ff, op_in;
   logic [P-1:0]                   fbank_ff, fbank_in;
   logic [blfcm_pkg::OFFSET_W-1:0] foff_ff, foff_in;
   logic [blfcm_pkg::BYTE_W-1:0]   fdata_ff, fdata_in;
   logic                           loaded_ff, loaded_in;

   // serial modulo
   logic [RW-1:0]  rem_ff;
   logic [P-1:0]   divd_ff;
   logic [SW-1:0]  step_ff;
   logic [RW-1:0]  rem_shift;
   logic [RW-1:0]  rem_next;
   blfcm_pkg::cnt_type eff_count;

   blfcm_pkg::rsp_type rsp_ff, rsp_in;

   logic [blfcm_pkg::ADDR_W-1:0] addr;
   logic [blfcm_pkg::BYTE_W-1:0] data;
   logic                         hi;
   logic                         at_latch, at_unlk1, at_unlk2;
   logic                         narrow;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_en_ff   <= 1'b0;
         variant_ff    <= 3'd0;
         nt_mode_ff    <= 2'd0;
         chr_mask_ff   <= 2'd3;
         bank_count_ff <= blfcm_pkg::cnt_type'(32);
      end else if (csr_valid) begin
         case (csr_index)
            blfcm_pkg::CSR_FLASH_ENABLED:  flash_en_ff   <= csr_data[0];
            blfcm_pkg::CSR_BOARD_VARIANT:  variant_ff    <= csr_data[2:0];
            blfcm_pkg::CSR_NAMETABLE_MODE: nt_mode_ff    <= csr_data[1:0];
            blfcm_pkg::CSR_CHR_BANK_MASK:  chr_mask_ff   <= csr_data[1:0];
            blfcm_pkg::CSR_PRG_BANK_COUNT: bank_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input decode
   assign addr     = req_payload.address;
   assign data     = req_payload.write_data;
   assign hi       = (addr >= blfcm_pkg::ADDR_LATCH);
   assign at_latch = (addr == blfcm_pkg::ADDR_LATCH);
   assign at_unlk1 = (addr == blfcm_pkg::ADDR_UNLK1);
   assign at_unlk2 = (addr == blfcm_pkg::ADDR_UNLK2);
   assign narrow   = (variant_ff == blfcm_pkg::VARIANT_1) ||
                     (variant_ff == blfcm_pkg::VARIANT_3) ||
                     (variant_ff == blfcm_pkg::VARIANT_4);

   // latch load and flash command sequencer
   always_comb begin
      latch_in  = latch_ff;
      seq_in    = seq_ff;
      tbank_in  = tbank_ff;
      idv_in    = idv_ff;
      op_in     = blfcm_pkg::FOP_NONE;
      fbank_in  = '0;
      foff_in   = '0;
      fdata_in  = '0;
      loaded_in = 1'b0;
      if (flash_en_ff) begin
         if (hi) begin
            latch_in  = data;
            loaded_in = 1'b1;
         end
         if (data == blfcm_pkg::DATA_RESET) begin
            seq_in = blfcm_pkg::SEQ_IDLE;
            idv_in = 1'b0;
         end else begin
            seq_in = blfcm_pkg::SEQ_IDLE;
            case (seq_ff)
               blfcm_pkg::SEQ_IDLE:
                  if (at_latch && data == blfcm_pkg::DATA_01) seq_in = blfcm_pkg::SEQ_U1;
               blfcm_pkg::SEQ_U1:
                  if (at_unlk1 && data == blfcm_pkg::DATA_AA) seq_in = blfcm_pkg::SEQ_U2;
               blfcm_pkg::SEQ_U2:
                  if (at_latch && data == blfcm_pkg::DATA_00) seq_in = blfcm_pkg::SEQ_U3;
               blfcm_pkg::SEQ_U3:
                  if (at_unlk2 && data == blfcm_pkg::DATA_55) seq_in = blfcm_pkg::SEQ_U4;
               blfcm_pkg::SEQ_U4:
                  if (at_latch && data == blfcm_pkg::DATA_01) seq_in = blfcm_pkg::SEQ_CMD;
               blfcm_pkg::SEQ_CMD: begin
                  if (at_unlk1 && data == blfcm_pkg::DATA_ID) idv_in = 1'b1;
                  else if (at_unlk1 && data == blfcm_pkg::DATA_PROGRAM)
                     seq_in = blfcm_pkg::SEQ_PGM_BANK;
                  else if (at_unlk1 && data == blfcm_pkg::DATA_ERASE)
                     seq_in = blfcm_pkg::SEQ_ERS_U1;
               end
               blfcm_pkg::SEQ_PGM_BANK:
                  if (hi) begin
                     tbank_in = data[P-1:0];
                     seq_in   = blfcm_pkg::SEQ_PGM_DATA;
                  end
               blfcm_pkg::SEQ_PGM_DATA:
                  if (!hi) begin
                     op_in    = blfcm_pkg::FOP_PROGRAM;
                     fbank_in = tbank_ff;
                     foff_in  = addr[blfcm_pkg::OFFSET_W-1:0];
                     fdata_in = data;
                  end
               blfcm_pkg::SEQ_ERS_U1:
                  if (at_unlk1 && data == blfcm_pkg::DATA_AA) seq_in = blfcm_pkg::SEQ_ERS_U2;
               blfcm_pkg::SEQ_ERS_U2:
                  if (at_latch && data == blfcm_pkg::DATA_00) seq_in = blfcm_pkg::SEQ_ERS_U3;
               blfcm_pkg::SEQ_ERS_U3:
                  if (at_unlk2 && data == blfcm_pkg::DATA_55) seq_in = blfcm_pkg::SEQ_ERS_BANK;
               blfcm_pkg::SEQ_ERS_BANK:
                  if (hi) begin
                     tbank_in = data[P-1:0];
                     seq_in   = blfcm_pkg::SEQ_ERS_DATA;
                  end
               blfcm_pkg::SEQ_ERS_DATA:
                  if (!hi && data == blfcm_pkg::DATA_SECTOR) begin
                     op_in    = blfcm_pkg::FOP_ERASE;
                     fbank_in = tbank_ff;
                     foff_in  = addr[blfcm_pkg::OFFSET_W-1:0] & blfcm_pkg::SECTOR_MASK;
                  end
               default: seq_in = blfcm_pkg::SEQ_IDLE;
            endcase
         end
      end else if (!(narrow && !hi)) begin
         // no flash: plain latch, with bus conflict on some variants
         if (variant_ff == blfcm_pkg::VARIANT_0 || variant_ff == blfcm_pkg::VARIANT_2)
            latch_in = data & req_payload.rom_value;
         else
            latch_in = data;
         loaded_in = 1'b1;
      end
   end

   // effective bank count: zero counts as one, clamp at the window size
   always_comb begin
      eff_count = bank_count_ff;
      if (bank_count_ff == '0) eff_count = blfcm_pkg::cnt_type'(1);
      else if (bank_count_ff > MAX_COUNT) eff_count = MAX_COUNT;
   end

   // one remainder bit per step, restoring form
   always_comb begin
      rem_shift = {rem_ff[P-1:0], divd_ff[P-1]};
      rem_next  = rem_shift;
      if (blfcm_pkg::cnt_type'(rem_shift) >= eff_count)
         rem_next = RW'(blfcm_pkg::cnt_type'(rem_shift) - eff_count);
   end

   assign status.last_step = (step_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
         seq_ff   <= blfcm_pkg::SEQ_IDLE;
         tbank_ff <= '0;
         idv_ff   <= 1'b0;
         step_ff  <= '0;
      end else if (cmd.load) begin
         latch_ff <= latch_in;
         seq_ff   <= seq_in;
         tbank_ff <= tbank_in;
         idv_ff   <= idv_in;
         step_ff  <= SW'(P - 1);
      end else if (cmd.step) begin
         step_ff  <= step_ff - 1'b1;
      end
   end

   // per-item payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_in;
         fbank_ff  <= fbank_in;
         foff_ff   <= foff_in;
         fdata_ff  <= fdata_in;
         loaded_ff <= loaded_in;
         rem_ff    <= '0;
         divd_ff   <= latch_in[P-1:0];
      end else if (cmd.step) begin
         rem_ff    <= rem_next;
         divd_ff   <= divd_ff << 1;
      end
   end

   // result assembly from updated state
   always_comb begin
      rsp_in               = '0;
      rsp_in.prg_bank      = blfcm_pkg::BANK_W'(rem_ff[P-1:0]);
      rsp_in.chr_bank      = latch_ff[6:5] & chr_mask_ff;
      if (variant_ff == blfcm_pkg::VARIANT_3) begin
         rsp_in.mirroring  = latch_ff[7] ? blfcm_pkg::MIR_VERTICAL
                                         : blfcm_pkg::MIR_HORIZONTAL;
      end else begin
         case (nt_mode_ff)
            blfcm_pkg::NT_VERTICAL:   rsp_in.mirroring = blfcm_pkg::MIR_VERTICAL;
            blfcm_pkg::NT_ONE_SCREEN: rsp_in.mirroring = latch_ff[7] ? blfcm_pkg::MIR_SCREEN_A
                                                                     : blfcm_pkg::MIR_SCREEN_B;
            blfcm_pkg::NT_FOUR:       rsp_in.mirroring = blfcm_pkg::MIR_FOUR;
            default:                  rsp_in.mirroring = blfcm_pkg::MIR_HORIZONTAL;
         endcase
      end
      rsp_in.id_view       = idv_ff;
      if (eff_count >= blfcm_pkg::cnt_type'(32))      rsp_in.device_id = blfcm_pkg::DEV_ID_32;
      else if (eff_count >= blfcm_pkg::cnt_type'(16)) rsp_in.device_id = blfcm_pkg::DEV_ID_16;
      else                                            rsp_in.device_id = blfcm_pkg::DEV_ID_LO;
      rsp_in.flash_op      = op_ff;
      rsp_in.flash_bank    = blfcm_pkg::BANK_W'(fbank_ff);
      rsp_in.flash_offset  = foff_ff;
      rsp_in.flash_data    = fdata_ff;
      rsp_in.latch_updated = loaded_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

### src/bank_latch_flash_command_mapper_core.sv
// Top level of the bank latch / flash command mapper.
// Joins blfcm_ctrl and blfcm_datapath; depends on blfcm_pkg.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_payload (address, write_data, rom_value)
//   rsp      out        rsp_valid/rsp_stall  rsp_payload (bank, mirroring, flash command)
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// Each item is accepted, updating the latch and sequencer, then runs the bit-serial
// bank modulo, and then has its result stored in the output register.
// A new item is taken while the previous result still waits in the output register.
// Reset is synchronous and active high; it clears the latch, sequencer and config.
// A stalled result holds; the controller waits before overwriting it.
module bank_latch_flash_command_mapper_core #(
   parameter int PRG_BANK_BITS = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  blfcm_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output blfcm_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [blfcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blfcm_pkg::CSR_DATA_W-1:0]   csr_data
);

   blfcm_pkg::ctl_cmd_type   cmd;
   blfcm_pkg::dp_status_type status;

   // config writes always taken
   assign csr_ready = 1'b1;

   blfcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   blfcm_datapath #(
      .PRG_BANK_BITS (PRG_BANK_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### sim/blfcm_checker.sv
// Scoreboard for the bank latch / flash command mapper: watches the req, rsp and csr
// transfers, predicts every result and compares it field by field.
// Depends on blfcm_pkg.
`timescale 1ns / 1ps
module blfcm_checker #(
   parameter int PRG_BANK_BITS = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  blfcm_pkg::req_type                 req_payload,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  blfcm_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [blfcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blfcm_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                 fail_count,
   output int                                 pending
);

   localparam int        BANK_LIMIT = 1 << PRG_BANK_BITS;
   localparam logic [4:0] BANK_MASK = 5'(BANK_LIMIT - 1);

   // Shadow configuration
   logic       flash_on;
   logic [2:0] variant;
   logic [1:0] nt_mode;
   logic [1:0] chr_mask;
   logic [5:0] bank_count;

   // Shadow mapper state
   logic [7:0]               latch;
   blfcm_pkg::flash_seq_type seq;
   logic [4:0]               target_bank;
   logic                     id_flag;

   blfcm_pkg::rsp_type bank_maps_due[$];
   int                 errors = 0;

   assign fail_count = errors;

   task automatic report(input string msg);
      errors++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string fname, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report($sformatf("%s is %0h, want %0h", fname, got, want));
      end
   endtask

   // Apply one CPU write to the shadow state and build the mapping it yields
   function automatic blfcm_pkg::rsp_type map_write(input blfcm_pkg::req_type w);
      blfcm_pkg::rsp_type       r;
      logic                     hi;
      logic                     narrow;
      logic [7:0]               d;
      int                       cnt;
      blfcm_pkg::flash_seq_type nxt;
      r  = '0;
      hi = w.address >= blfcm_pkg::ADDR_LATCH;
      d  = w.write_data;
      if (flash_on) begin
         if (hi) begin
            latch = d;
            r.latch_updated = 1'b1;
         end
         // reset data wins in every sequencer state
         if (d == blfcm_pkg::DATA_RESET) begin
            seq     = blfcm_pkg::SEQ_IDLE;
            id_flag = 1'b0;
         end else begin
            nxt = blfcm_pkg::SEQ_IDLE;
            case (seq)
               blfcm_pkg::SEQ_IDLE:
                  if (w.address == blfcm_pkg::ADDR_LATCH && d == blfcm_pkg::DATA_01)
                     nxt = blfcm_pkg::SEQ_U1;
               blfcm_pkg::SEQ_U1:
                  if (w.address == blfcm_pkg::ADDR_UNLK1 && d == blfcm_pkg::DATA_AA)
                     nxt = blfcm_pkg::SEQ_U2;
               blfcm_pkg::SEQ_U2:
                  if (w.address == blfcm_pkg::ADDR_LATCH && d == blfcm_pkg::DATA_00)
                     nxt = blfcm_pkg::SEQ_U3;
               blfcm_pkg::SEQ_U3:
                  if (w.address == blfcm_pkg::ADDR_UNLK2 && d == blfcm_pkg::DATA_55)
                     nxt = blfcm_pkg::SEQ_U4;
               blfcm_pkg::SEQ_U4:
                  if (w.address == blfcm_pkg::ADDR_LATCH && d == blfcm_pkg::DATA_01)
                     nxt = blfcm_pkg::SEQ_CMD;
               blfcm_pkg::SEQ_CMD: begin
                  if (w.address == blfcm_pkg::ADDR_UNLK1) begin
                     if (d == blfcm_pkg::DATA_ID) id_flag = 1'b1;
                     else if (d == blfcm_pkg::DATA_PROGRAM) nxt = blfcm_pkg::SEQ_PGM_BANK;
                     else if (d == blfcm_pkg::DATA_ERASE) nxt = blfcm_pkg::SEQ_ERS_U1;
                  end
               end
               blfcm_pkg::SEQ_PGM_BANK: begin
                  if (hi) begin
                     target_bank = d[4:0] & BANK_MASK;
                     nxt = blfcm_pkg::SEQ_PGM_DATA;
                  end
               end
               blfcm_pkg::SEQ_PGM_DATA: begin
                  if (!hi) begin
                     r.flash_op     = blfcm_pkg::FOP_PROGRAM;
                     r.flash_bank   = target_bank;
                     r.flash_offset = w.address[13:0];
                     r.flash_data   = d;
                  end
               end
               blfcm_pkg::SEQ_ERS_U1:
                  if (w.address == blfcm_pkg::ADDR_UNLK1 && d == blfcm_pkg::DATA_AA)
                     nxt = blfcm_pkg::SEQ_ERS_U2;
               blfcm_pkg::SEQ_ERS_U2:
                  if (w.address == blfcm_pkg::ADDR_LATCH && d == blfcm_pkg::DATA_00)
                     nxt = blfcm_pkg::SEQ_ERS_U3;
               blfcm_pkg::SEQ_ERS_U3:
                  if (w.address == blfcm_pkg::ADDR_UNLK2 && d == blfcm_pkg::DATA_55)
                     nxt = blfcm_pkg::SEQ_ERS_BANK;
               blfcm_pkg::SEQ_ERS_BANK: begin
                  if (hi) begin
                     target_bank = d[4:0] & BANK_MASK;
                     nxt = blfcm_pkg::SEQ_ERS_DATA;
                  end
               end
               blfcm_pkg::SEQ_ERS_DATA: begin
                  if (!hi && d == blfcm_pkg::DATA_SECTOR) begin
                     r.flash_op     = blfcm_pkg::FOP_ERASE;
                     r.flash_bank   = target_bank;
                     r.flash_offset = w.address[13:0] & blfcm_pkg::SECTOR_MASK;
                  end
               end
               default: nxt = blfcm_pkg::SEQ_IDLE;
            endcase
            seq = nxt;
         end
      end else begin
         // plain latch board: narrow decode and bus conflicts by variant
         narrow = variant == blfcm_pkg::VARIANT_1 || variant == blfcm_pkg::VARIANT_3 ||
                  variant == blfcm_pkg::VARIANT_4;
         if (!(narrow && !hi)) begin
            if (variant == blfcm_pkg::VARIANT_0 || variant == blfcm_pkg::VARIANT_2)
               d &= w.rom_value;
            latch = d;
            r.latch_updated = 1'b1;
         end
      end

      cnt = bank_count;
      if (cnt == 0) cnt = 1;
      if (cnt > BANK_LIMIT) cnt = BANK_LIMIT;
      r.prg_bank = 5'((latch[4:0] & BANK_MASK) % cnt);
      r.chr_bank = latch[6:5] & chr_mask;
      if (variant == blfcm_pkg::VARIANT_3) begin
         r.mirroring = latch[7] ? blfcm_pkg::MIR_VERTICAL : blfcm_pkg::MIR_HORIZONTAL;
      end else begin
         case (nt_mode)
            blfcm_pkg::NT_VERTICAL:   r.mirroring = blfcm_pkg::MIR_VERTICAL;
            blfcm_pkg::NT_ONE_SCREEN: r.mirroring = latch[7] ? blfcm_pkg::MIR_SCREEN_A
                                                             : blfcm_pkg::MIR_SCREEN_B;
            blfcm_pkg::NT_FOUR:       r.mirroring = blfcm_pkg::MIR_FOUR;
            default:                  r.mirroring = blfcm_pkg::MIR_HORIZONTAL;
         endcase
      end
      r.id_view   = id_flag;
      r.device_id = cnt >= 32 ? blfcm_pkg::DEV_ID_32
                              : (cnt >= 16 ? blfcm_pkg::DEV_ID_16 : blfcm_pkg::DEV_ID_LO);
      return r;
   endfunction

   // Watch all three channels on the rising edge
   always @(posedge clock) begin : watch
      blfcm_pkg::rsp_type want;
      if (reset) begin
         flash_on    = 1'b0;
         variant     = blfcm_pkg::VARIANT_0;
         nt_mode     = blfcm_pkg::NT_HORIZONTAL;
         chr_mask    = 2'd3;
         bank_count  = 6'd32;
         latch       = '0;
         seq         = blfcm_pkg::SEQ_IDLE;
         target_bank = '0;
         id_flag     = 1'b0;
         bank_maps_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               blfcm_pkg::CSR_FLASH_ENABLED:  flash_on   = csr_data[0];
               blfcm_pkg::CSR_BOARD_VARIANT:  variant    = csr_data[2:0];
               blfcm_pkg::CSR_NAMETABLE_MODE: nt_mode    = csr_data[1:0];
               blfcm_pkg::CSR_CHR_BANK_MASK:  chr_mask   = csr_data[1:0];
               blfcm_pkg::CSR_PRG_BANK_COUNT: bank_count = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            bank_maps_due.push_back(map_write(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (bank_maps_due.size() == 0) begin
               report("result transfer with nothing outstanding");
            end else begin
               want = bank_maps_due.pop_front();
               check_field("prg_bank", rsp_payload.prg_bank, want.prg_bank);
               check_field("chr_bank", rsp_payload.chr_bank, want.chr_bank);
               check_field("mirroring", rsp_payload.mirroring, want.mirroring);
               check_field("id_view", rsp_payload.id_view, want.id_view);
               check_field("device_id", rsp_payload.device_id, want.device_id);
               check_field("flash_op", rsp_payload.flash_op, want.flash_op);
               check_field("flash_bank", rsp_payload.flash_bank, want.flash_bank);
               check_field("flash_offset", rsp_payload.flash_offset, want.flash_offset);
               check_field("flash_data", rsp_payload.flash_data, want.flash_data);
               check_field("latch_updated", rsp_payload.latch_updated,
                           want.latch_updated);
            end
         end
      end
      pending = bank_maps_due.size();
   end

endmodule

### sim/testbench.sv
// Top of the mapper testbench: clock, reset, csr setup, CPU write stimulus and
// random result back-pressure. Instantiates bank_latch_flash_command_mapper_core
// and blfcm_checker; depends on blfcm_pkg.
`timescale 1ns / 1ps
module testbench;

   localparam int PRG_BANK_BITS = 5;
   localparam int ITEM_CYCLES   = PRG_BANK_BITS + 2;
   localparam int PHASES        = 10;
   localparam int PHASE_WRITES  = 190;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   blfcm_pkg::req_type               req_payload;
   logic                             rsp_valid;
   logic                             rsp_stall;
   blfcm_pkg::rsp_type               rsp_payload;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [blfcm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [blfcm_pkg::CSR_DATA_W-1:0] csr_data;
   int                               fail_count;
   int                               pending;
   int                               stall_pct = 0;

   blfcm_pkg::req_type burst[$];

   // Per-phase settings; the first columns cover the extremes
   int flash_tbl   [PHASES] = '{1, 0, 1, 1, 0, 1, 1, 0, 1, 1};
   int variant_tbl [PHASES] = '{0, 1, 2, 3, 4, 5, 6, 7, 3, 2};
   int chr_tbl     [PHASES] = '{3, 0, 1, 2, 3, 0, 1, 3, 2, 3};
   int count_tbl   [PHASES] = '{32, 1, 63, 0, 16, 15, 17, 7, 31, 33};
   int gap_tbl     [PHASES] = '{0, 20, 50, 10, 0, 30, 60, 5, 20, 40};
   int stall_tbl   [PHASES] = '{30, 0, 50, 10, 0, 20, 60, 40, 0, 25};

   bank_latch_flash_command_mapper_core #(
      .PRG_BANK_BITS(PRG_BANK_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   blfcm_checker #(
      .PRG_BANK_BITS(PRG_BANK_BITS)
   ) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #(6_000_000);
      $display("simulation failed");
      $finish;
   end

   // Idle length: mostly short, now and then long
   function automatic int gap_len(input int pct);
      if ($urandom_range(99, 0) >= pct) return 0;
      if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   // Result side back-pressure
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         run = gap_len(stall_pct);
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [15:0] lo_addr();
      return 16'h8000 + 16'($urandom_range(16'h3FFF, 0));
   endfunction

   function automatic logic [15:0] hi_addr();
      return 16'hC000 + 16'($urandom_range(16'h3FFF, 0));
   endfunction

   function automatic logic [7:0] pick_data();
      case ($urandom_range(11, 0))
         0: return blfcm_pkg::DATA_01;
         1: return blfcm_pkg::DATA_AA;
         2: return blfcm_pkg::DATA_00;
         3: return blfcm_pkg::DATA_55;
         4: return blfcm_pkg::DATA_ID;
         5: return blfcm_pkg::DATA_PROGRAM;
         6: return blfcm_pkg::DATA_ERASE;
         7: return blfcm_pkg::DATA_SECTOR;
         8: return blfcm_pkg::DATA_RESET;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(9, 0))
         0: return blfcm_pkg::ADDR_LATCH;
         1: return blfcm_pkg::ADDR_UNLK1;
         2: return blfcm_pkg::ADDR_UNLK2;
         3: return 16'($urandom_range(16'h7FFF, 0));
         4, 5, 6: return lo_addr();
         default: return hi_addr();
      endcase
   endfunction

   task automatic push_write(input logic [15:0] a, input logic [7:0] d,
                             input logic [7:0] rom);
      blfcm_pkg::req_type w;
      w.address    = a;
      w.write_data = d;
      w.rom_value  = rom;
      burst.push_back(w);
   endtask

   task automatic push_unlock();
      push_write(blfcm_pkg::ADDR_LATCH, blfcm_pkg::DATA_01, 8'($urandom));
      push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_AA, 8'($urandom));
      push_write(blfcm_pkg::ADDR_LATCH, blfcm_pkg::DATA_00, 8'($urandom));
      push_write(blfcm_pkg::ADDR_UNLK2, blfcm_pkg::DATA_55, 8'($urandom));
      push_write(blfcm_pkg::ADDR_LATCH, blfcm_pkg::DATA_01, 8'($urandom));
   endtask

   // Mostly complete flash commands with random content; some broken, some noise
   task automatic gen_flash_writes();
      int first;
      int idx;
      if ($urandom_range(99, 0) < 70) begin
         first = burst.size();
         push_unlock();
         case ($urandom_range(2, 0))
            0: begin
               push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_ID, 8'($urandom));
               if ($urandom_range(2, 0) == 0)
                  push_write(pick_addr(), blfcm_pkg::DATA_RESET, 8'($urandom));
            end
            1: begin
               push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_PROGRAM, 8'($urandom));
               push_write(hi_addr(), 8'($urandom), 8'($urandom));
               push_write($urandom_range(9, 0) == 0 ? hi_addr() : lo_addr(),
                          8'($urandom), 8'($urandom));
            end
            default: begin
               push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_ERASE, 8'($urandom));
               push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_AA, 8'($urandom));
               push_write(blfcm_pkg::ADDR_LATCH, blfcm_pkg::DATA_00, 8'($urandom));
               push_write(blfcm_pkg::ADDR_UNLK2, blfcm_pkg::DATA_55, 8'($urandom));
               push_write(hi_addr(), 8'($urandom), 8'($urandom));
               push_write($urandom_range(9, 0) == 0 ? hi_addr() : lo_addr(),
                          $urandom_range(6, 0) == 0 ? 8'($urandom)
                                                    : blfcm_pkg::DATA_SECTOR,
                          8'($urandom));
            end
         endcase
         // break a step now and then
         if ($urandom_range(99, 0) < 15) begin
            idx = $urandom_range(burst.size() - 1, first);
            if ($urandom_range(1, 0) == 0) burst[idx].write_data = blfcm_pkg::DATA_RESET;
            else burst[idx].address = pick_addr();
         end
      end else begin
         push_write(pick_addr(), pick_data(), 8'($urandom));
      end
   endtask

   // Plain latch writes; a few fall outside cartridge space
   task automatic gen_plain_write();
      logic [15:0] a;
      logic [7:0]  rom;
      a = $urandom_range(99, 0) < 3 ? 16'($urandom_range(16'h7FFF, 0))
                                     : 16'($urandom_range(16'hFFFF, 16'h8000));
      case ($urandom_range(5, 0))
         0: rom = 8'hFF;
         1: rom = 8'h00;
         default: rom = 8'($urandom);
      endcase
      push_write(a, 8'($urandom), rom);
   endtask

   task automatic send_write(input blfcm_pkg::req_type w, input int idle_pct);
      int g;
      req_payload <= w;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      g = gap_len(idle_pct);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic send_burst(input int idle_pct);
      while (burst.size() > 0) send_write(burst.pop_front(), idle_pct);
   endtask

   // Hold the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic set_config(input logic fe, input logic [2:0] variant_sel,
                             input logic [1:0] nt, input logic [1:0] cmask,
                             input logic [5:0] count);
      logic [blfcm_pkg::CSR_IDX_W-1:0]  idxs [5];
      logic [blfcm_pkg::CSR_DATA_W-1:0] vals [5];
      idxs = '{blfcm_pkg::CSR_FLASH_ENABLED, blfcm_pkg::CSR_BOARD_VARIANT,
               blfcm_pkg::CSR_NAMETABLE_MODE, blfcm_pkg::CSR_CHR_BANK_MASK,
               blfcm_pkg::CSR_PRG_BANK_COUNT};
      vals = '{6'(fe), 6'(variant_sel), 6'(nt), 6'(cmask), count};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idxs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Stimulus
   initial begin
      int  sent;
      bit  paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: flash off, bus conflict on variant 0
      push_write(16'h8000, 8'hFF, 8'h0F);
      push_write(16'hFFFF, 8'hFF, 8'hFF);
      send_burst(0);
      drain();

      // flash on: ID entry, program at the top offset, sector erase, then reset data
      set_config(1'b1, blfcm_pkg::VARIANT_0, blfcm_pkg::NT_ONE_SCREEN, 2'd3, 6'd32);
      push_unlock();
      push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_ID, 8'h00);
      push_unlock();
      push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_PROGRAM, 8'h00);
      push_write(16'hFFFF, 8'hFF, 8'h00);
      push_write(16'hBFFF, 8'h5A, 8'h00);
      push_unlock();
      push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_ERASE, 8'h00);
      push_write(blfcm_pkg::ADDR_UNLK1, blfcm_pkg::DATA_AA, 8'h00);
      push_write(blfcm_pkg::ADDR_LATCH, blfcm_pkg::DATA_00, 8'h00);
      push_write(blfcm_pkg::ADDR_UNLK2, blfcm_pkg::DATA_55, 8'h00);
      push_write(blfcm_pkg::ADDR_LATCH, 8'h03, 8'h00);
      push_write(16'hB456, blfcm_pkg::DATA_SECTOR, 8'h00);
      push_write(16'h8000, blfcm_pkg::DATA_RESET, 8'h00);
      send_burst(0);

      // random phases, one setting each
      for (int p = 0; p < PHASES; p++) begin
         drain();
         set_config(flash_tbl[p][0], 3'(variant_tbl[p]), 2'(p % 4),
                    2'(chr_tbl[p]), 6'(count_tbl[p]));
         stall_pct = stall_tbl[p];
         sent   = 0;
         paused = 0;
         while (sent < PHASE_WRITES) begin
            if (flash_tbl[p] != 0) gen_flash_writes();
            else gen_plain_write();
            sent += burst.size();
            send_burst(gap_tbl[p]);
            if (!paused && sent >= PHASE_WRITES / 2) begin
               drain();
               paused = 1;
            end
         end
      end

      drain();
      repeat (4 * ITEM_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
